FILE: sv/itee_pkg.sv
package itee_pkg;

    // Widths of the token and result words
    localparam int VAL_W  = 64;
    localparam int KIND_W = 5;
    localparam int UNIT_W = 33;
    localparam int ERR_W  = 2;
    localparam int CLS_W  = 4;

    localparam int MAX_TOKENS_DEF = 128;

    typedef logic [VAL_W-1:0]  t_value;
    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [CLS_W-1:0]  t_class;
    typedef logic [ERR_W-1:0]  t_err;

    localparam logic [UNIT_W-1:0] UNIT_RST = 33'd1000000000;

    // Token kinds
    localparam t_kind K_LIT     = 5'd0;
    localparam t_kind K_LPAREN  = 5'd1;
    localparam t_kind K_RPAREN  = 5'd2;
    localparam t_kind K_NOT     = 5'd3;
    localparam t_kind K_MUL     = 5'd4;
    localparam t_kind K_INTDIV  = 5'd5;
    localparam t_kind K_FRACDIV = 5'd6;
    localparam t_kind K_MOD     = 5'd7;
    localparam t_kind K_ADD     = 5'd8;
    localparam t_kind K_SUB     = 5'd9;
    localparam t_kind K_GT      = 5'd10;
    localparam t_kind K_GE      = 5'd11;
    localparam t_kind K_LT      = 5'd12;
    localparam t_kind K_LE      = 5'd13;
    localparam t_kind K_EQ      = 5'd14;
    localparam t_kind K_NE      = 5'd15;
    localparam t_kind K_AND     = 5'd16;
    localparam t_kind K_OR      = 5'd17;

    // Binding classes, strongest first
    localparam t_class C_PAREN_HI = 4'd1;
    localparam t_class C_NOT      = 4'd2;
    localparam t_class C_LIT      = 4'd10;
    localparam t_class C_NONE     = 4'd11;

    // Error codes
    localparam t_err E_OK    = 2'd0;
    localparam t_err E_PAREN = 2'd1;
    localparam t_err E_INVAL = 2'd2;
    localparam t_err E_LONG  = 2'd3;

    localparam t_value V_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam t_value V_MIN = 64'h8000_0000_0000_0000;

    function automatic t_class f_kind_class(input t_kind k);
        t_class c;
        case (k)
            K_LIT:                              c = C_LIT;
            K_LPAREN:                           c = 4'd0;
            K_RPAREN:                           c = 4'd1;
            K_NOT:                              c = C_NOT;
            K_MUL, K_INTDIV, K_FRACDIV, K_MOD:  c = 4'd3;
            K_ADD, K_SUB:                       c = 4'd4;
            K_GT, K_GE, K_LT, K_LE:             c = 4'd5;
            K_EQ:                               c = 4'd6;
            K_NE:                               c = 4'd7;
            K_AND:                              c = 4'd8;
            K_OR:                               c = 4'd9;
            default:                            c = C_NONE;
        endcase
        return c;
    endfunction

endpackage

FILE: sv/infix_token_expression_evaluator_unit.sv
// Infix expression evaluator over a stream of lexed tokens.
// Input stream: one token per word; s_axis_tuser carries the token kind,
// s_axis_tdata the signed fixed-point literal, s_axis_tlast ends the
// expression. Tokens load one per cycle into a linked list in memory.
// After the last word the block drops s_axis_tready and a sequencer walks
// the list: a paren scan, then a scan of the innermost group for its
// strongest operator, then one reduction, repeated until one literal is
// left. Each list entry visited takes a head, a read and a check state (registered read).
// mul, intdiv, fracdiv and mod go through one shared shift-add multiplier
// and restoring divider; intdiv runs them twice. Simple operators are
// computed combinationally, with no multiplier or divider pass, so the
// time to a result is data dependent.
// Output stream: one word per expression; m_axis_tdata is the value,
// m_axis_tuser the error code and the divide-by-zero flag. A stalled
// receiver holds the result word; loading of the next expression goes on
// meanwhile, and a new result waits until the old word is taken.
// i_cfg_we writes unit_value, the raw value of one; write it only while idle.
// Reset (synchronous, active low) empties the list and the output word.
module infix_token_expression_evaluator_unit #(
    parameter int MAX_TOKENS = itee_pkg::MAX_TOKENS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [itee_pkg::UNIT_W-1:0]   i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [itee_pkg::VAL_W-1:0]    s_axis_tdata,   // [63:0] literal_value
    input  logic [itee_pkg::KIND_W-1:0]   s_axis_tuser,   // [4:0] op
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [itee_pkg::VAL_W-1:0]    m_axis_tdata,   // [63:0] result_value
    output logic [itee_pkg::ERR_W:0]      m_axis_tuser    // [1:0] error_code, [2] divided_by_zero
);
    import itee_pkg::*;

    localparam int PW = $clog2(MAX_TOKENS + 1);
    localparam int AW = $clog2(MAX_TOKENS);
    localparam int SW = 7;
    localparam logic [SW-1:0] MUL_LAST = 7'd63;
    localparam logic [SW-1:0] DIV_LAST = 7'd127;
    localparam logic [PW-1:0] CNT_MAX  = PW'(MAX_TOKENS);

    localparam logic [4:0] S_LOAD    = 5'd0;
    localparam logic [4:0] S_START   = 5'd1;
    localparam logic [4:0] S_PS_INIT = 5'd2;
    localparam logic [4:0] S_PS_HEAD = 5'd3;
    localparam logic [4:0] S_PS_RD   = 5'd4;
    localparam logic [4:0] S_PS_CHK  = 5'd5;
    localparam logic [4:0] S_PS_END  = 5'd6;
    localparam logic [4:0] S_RS_INIT = 5'd7;
    localparam logic [4:0] S_RS_HEAD = 5'd8;
    localparam logic [4:0] S_RS_RD   = 5'd9;
    localparam logic [4:0] S_RS_CHK  = 5'd10;
    localparam logic [4:0] S_RS_END  = 5'd11;
    localparam logic [4:0] S_NX_RD   = 5'd12;
    localparam logic [4:0] S_NX_CHK  = 5'd13;
    localparam logic [4:0] S_PL_RD   = 5'd14;
    localparam logic [4:0] S_PL_CHK  = 5'd15;
    localparam logic [4:0] S_MUL     = 5'd16;
    localparam logic [4:0] S_DIV     = 5'd17;
    localparam logic [4:0] S_OP_DONE = 5'd18;
    localparam logic [4:0] S_FIN     = 5'd19;

    // Token list storage
    t_kind          mem_kind [MAX_TOKENS];
    t_value         mem_val  [MAX_TOKENS];
    logic [PW-1:0]  mem_next [MAX_TOKENS];

    logic [4:0]     r_state;
    logic [UNIT_W-1:0] r_unit;
    logic [PW-1:0]  r_cnt;
    logic           r_ovf;
    logic           r_badkind;
    logic           r_dbz;
    logic [PW-1:0]  r_addr;
    t_kind          r_rd_kind;
    t_value         r_rd_val;
    logic [PW-1:0]  r_rd_next;

    logic [PW-1:0]  r_i;
    logic [PW-1:0]  r_beg;
    logic           r_beg_ok;
    logic [PW-1:0]  r_begnext;
    logic [PW-1:0]  r_endi;
    logic           r_end_ok;
    logic [PW-1:0]  r_endnext;
    logic [PW-1:0]  r_endv;

    logic [PW-1:0]  r_prev;
    logic           r_prev_ok;
    t_kind          r_prev_kind;
    t_class         r_best;
    logic           r_loc_ok;
    logic [PW-1:0]  r_loc;
    t_kind          r_loc_kind;
    logic [PW-1:0]  r_loc_next;
    t_value         r_loc_val;
    logic [PW-1:0]  r_ploc;
    logic           r_ploc_ok;
    t_kind          r_ploc_kind;
    t_value         r_nx_val;
    logic [PW-1:0]  r_nx_next;

    logic [127:0]   r_acc;
    logic [127:0]   r_mx;
    logic [63:0]    r_my;
    logic [63:0]    r_d;
    logic [63:0]    r_rem;
    logic [SW-1:0]  r_step;
    logic           r_neg;
    logic           r_a_neg;
    logic           r_pass2;

    t_value         r_res;
    t_err           r_err;
    logic           r_m_valid;
    t_value         r_m_data;
    logic [ERR_W:0] r_m_user;

    logic           s_acc;
    logic [PW-1:0]  cnt_inc;
    logic [63:0]    ueff;
    t_class         rd_class;
    t_value         a_val;
    t_value         b_val;
    logic [63:0]    mag_a;
    logic [63:0]    mag_b;
    logic           long_op;
    logic           div_zero;
    t_value         simple_res;
    t_value         sum;
    t_value         diff;
    logic           lt_ab;
    logic           lt_ba;
    logic [64:0]    div_r2;
    logic [64:0]    div_sub;
    logic           div_ge;
    t_value         lim;
    t_value         sat_q;
    t_value         op_res;

    logic           w_kind_en;
    logic           w_val_en;
    logic           w_next_en;
    logic [PW-1:0]  w_addr;
    t_kind          w_kind;
    t_value         w_val;
    logic [PW-1:0]  w_next;

    assign s_axis_tready = (r_state == S_LOAD);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign cnt_inc       = r_cnt + 1'b1;
    assign ueff          = (r_unit == '0) ? 64'd1 : {{(64-UNIT_W){1'b0}}, r_unit};
    assign rd_class      = f_kind_class(r_rd_kind);

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    // Operand decode for the binary step
    assign a_val    = r_rd_val;
    assign b_val    = r_nx_val;
    assign mag_a    = a_val[63] ? (64'd0 - a_val) : a_val;
    assign mag_b    = b_val[63] ? (64'd0 - b_val) : b_val;
    assign long_op  = (r_loc_kind inside {K_MUL, K_INTDIV, K_FRACDIV, K_MOD});
    assign div_zero = (r_loc_kind inside {K_INTDIV, K_FRACDIV, K_MOD}) && (b_val == '0);
    assign sum      = a_val + b_val;
    assign diff     = a_val - b_val;
    assign lt_ab    = $signed(a_val) < $signed(b_val);
    assign lt_ba    = $signed(b_val) < $signed(a_val);

    // Combinational operators: saturating add/sub, compares, logic
    always_comb begin
        case (r_loc_kind)
            K_ADD: begin
                if ((a_val[63] == b_val[63]) && (sum[63] != a_val[63]))
                    simple_res = a_val[63] ? V_MIN : V_MAX;
                else
                    simple_res = sum;
            end
            K_SUB: begin
                if ((a_val[63] != b_val[63]) && (diff[63] != a_val[63]))
                    simple_res = a_val[63] ? V_MIN : V_MAX;
                else
                    simple_res = diff;
            end
            K_GT:    simple_res = lt_ba ? ueff : '0;
            K_GE:    simple_res = !lt_ab ? ueff : '0;
            K_LT:    simple_res = lt_ab ? ueff : '0;
            K_LE:    simple_res = !lt_ba ? ueff : '0;
            K_EQ:    simple_res = (a_val == b_val) ? ueff : '0;
            K_NE:    simple_res = (a_val != b_val) ? ueff : '0;
            K_AND:   simple_res = ((a_val != '0) && (b_val != '0)) ? ueff : '0;
            K_OR:    simple_res = ((a_val != '0) || (b_val != '0)) ? ueff : '0;
            default: simple_res = '0;
        endcase
    end

    // Restoring divider step and final saturation
    assign div_r2  = {r_rem, r_acc[127]};
    assign div_sub = div_r2 - {1'b0, r_d};
    assign div_ge  = (div_r2 >= {1'b0, r_d});
    assign lim     = r_neg ? V_MIN : V_MAX;
    assign sat_q   = ((r_acc[127:64] != '0) || (r_acc[63:0] > lim)) ? lim : r_acc[63:0];
    assign op_res  = (r_loc_kind == K_MOD) ? (r_a_neg ? (64'd0 - r_rem) : r_rem)
                   : (r_neg ? (64'd0 - sat_q) : sat_q);

    // Memory write port
    always_comb begin
        w_kind_en = 1'b0;
        w_val_en  = 1'b0;
        w_next_en = 1'b0;
        w_addr    = r_cnt;
        w_kind    = s_axis_tuser;
        w_val     = s_axis_tdata;
        w_next    = cnt_inc;
        case (r_state)
            S_LOAD: begin
                if (s_acc && !r_ovf) begin
                    w_kind_en = 1'b1;
                    w_val_en  = 1'b1;
                    w_next_en = 1'b1;
                end
            end
            S_RS_END: begin
                if (r_loc_ok && (r_best == C_LIT) && r_beg_ok) begin
                    w_kind_en = 1'b1;
                    w_val_en  = 1'b1;
                    w_next_en = 1'b1;
                    w_addr    = r_beg;
                    w_kind    = K_LIT;
                    w_val     = r_loc_val;
                    w_next    = r_endnext;
                end
            end
            S_NX_CHK: begin
                if ((r_rd_kind == K_LIT) && (r_best == C_NOT)) begin
                    w_kind_en = 1'b1;
                    w_val_en  = 1'b1;
                    w_next_en = 1'b1;
                    w_addr    = r_loc;
                    w_kind    = K_LIT;
                    w_val     = (r_rd_val == '0) ? ueff : '0;
                    w_next    = r_rd_next;
                end
            end
            S_PL_CHK: begin
                if (!long_op || div_zero) begin
                    w_val_en  = 1'b1;
                    w_next_en = 1'b1;
                    w_addr    = r_ploc;
                    w_val     = div_zero ? '0 : simple_res;
                    w_next    = r_nx_next;
                end
            end
            S_OP_DONE: begin
                if (!r_pass2) begin
                    w_val_en  = 1'b1;
                    w_next_en = 1'b1;
                    w_addr    = r_ploc;
                    w_val     = op_res;
                    w_next    = r_nx_next;
                end
            end
            default: begin
            end
        endcase
    end

    // Write and read the list memories
    always_ff @(posedge i_clk) begin
        if (w_kind_en)
            mem_kind[w_addr[AW-1:0]] <= w_kind;
        if (w_val_en)
            mem_val[w_addr[AW-1:0]] <= w_val;
        if (w_next_en)
            mem_next[w_addr[AW-1:0]] <= w_next;
        r_rd_kind <= mem_kind[r_addr[AW-1:0]];
        r_rd_val  <= mem_val[r_addr[AW-1:0]];
        r_rd_next <= mem_next[r_addr[AW-1:0]];
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_unit    <= UNIT_RST;
            r_cnt     <= '0;
            r_ovf     <= 1'b0;
            r_badkind <= 1'b0;
            r_dbz     <= 1'b0;
            r_m_valid <= 1'b0;
            r_pass2   <= 1'b0;
        end else begin
            if (i_cfg_we)
                r_unit <= i_cfg_wdata;
            // Retire the output word once taken; the final state reloads it itself
            if (r_m_valid && m_axis_tready && (r_state != S_FIN))
                r_m_valid <= 1'b0;

            case (r_state)
                // Append tokens; drop them once the list is full
                S_LOAD: begin
                    if (s_acc) begin
                        if (!r_ovf) begin
                            r_cnt <= cnt_inc;
                            if (cnt_inc == CNT_MAX)
                                r_ovf <= 1'b1;
                            if (s_axis_tuser > K_OR)
                                r_badkind <= 1'b1;
                        end
                        if (s_axis_tlast) begin
                            r_dbz   <= 1'b0;
                            r_state <= S_START;
                        end
                    end
                end
                S_START: begin
                    r_res <= '0;
                    if (r_badkind) begin
                        r_err   <= E_INVAL;
                        r_state <= S_FIN;
                    end else if (r_ovf) begin
                        r_err   <= E_LONG;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_PS_INIT;
                    end
                end
                // Find the first right paren and the last left paren before it
                S_PS_INIT: begin
                    r_i      <= '0;
                    r_beg_ok <= 1'b0;
                    r_end_ok <= 1'b0;
                    r_state  <= S_PS_HEAD;
                end
                S_PS_HEAD: begin
                    r_addr  <= r_i;
                    r_state <= (r_i < r_cnt) ? S_PS_RD : S_PS_END;
                end
                S_PS_RD: r_state <= S_PS_CHK;
                S_PS_CHK: begin
                    r_i <= r_rd_next;
                    if (r_rd_kind == K_LPAREN) begin
                        r_beg     <= r_i;
                        r_beg_ok  <= 1'b1;
                        r_begnext <= r_rd_next;
                        r_state   <= S_PS_HEAD;
                    end else if (r_rd_kind == K_RPAREN) begin
                        r_endi    <= r_i;
                        r_end_ok  <= 1'b1;
                        r_endnext <= r_rd_next;
                        r_state   <= S_PS_END;
                    end else begin
                        r_state <= S_PS_HEAD;
                    end
                end
                S_PS_END: begin
                    r_endv <= r_end_ok ? r_endi : r_cnt;
                    if (r_end_ok != r_beg_ok) begin
                        r_err   <= E_PAREN;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_RS_INIT;
                    end
                end
                // Scan the group for the leftmost strongest token
                S_RS_INIT: begin
                    r_i       <= r_beg_ok ? r_begnext : '0;
                    r_best    <= C_NONE;
                    r_loc_ok  <= 1'b0;
                    r_prev_ok <= 1'b0;
                    r_state   <= S_RS_HEAD;
                end
                S_RS_HEAD: begin
                    r_addr  <= r_i;
                    r_state <= (r_i < r_endv) ? S_RS_RD : S_RS_END;
                end
                S_RS_RD: r_state <= S_RS_CHK;
                S_RS_CHK: begin
                    if (rd_class < r_best) begin
                        r_best      <= rd_class;
                        r_loc_ok    <= 1'b1;
                        r_loc       <= r_i;
                        r_loc_kind  <= r_rd_kind;
                        r_loc_next  <= r_rd_next;
                        r_loc_val   <= r_rd_val;
                        r_ploc      <= r_prev;
                        r_ploc_ok   <= r_prev_ok;
                        r_ploc_kind <= r_prev_kind;
                    end
                    r_prev      <= r_i;
                    r_prev_ok   <= 1'b1;
                    r_prev_kind <= r_rd_kind;
                    r_i         <= r_rd_next;
                    r_state     <= S_RS_HEAD;
                end
                S_RS_END: begin
                    r_addr <= r_loc_next;
                    if (!r_loc_ok) begin
                        r_err   <= E_INVAL;
                        r_state <= S_FIN;
                    end else if (r_best == C_LIT) begin
                        if (r_beg_ok) begin
                            r_state <= S_PS_INIT;
                        end else begin
                            r_res   <= r_loc_val;
                            r_err   <= E_OK;
                            r_state <= S_FIN;
                        end
                    end else if (r_loc_next >= r_cnt) begin
                        r_err   <= E_INVAL;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_NX_RD;
                    end
                end
                // Check the right operand
                S_NX_RD: r_state <= S_NX_CHK;
                S_NX_CHK: begin
                    r_nx_val  <= r_rd_val;
                    r_nx_next <= r_rd_next;
                    r_addr    <= r_ploc;
                    if (r_rd_kind != K_LIT) begin
                        r_err   <= E_INVAL;
                        r_state <= S_FIN;
                    end else if (r_best == C_NOT) begin
                        r_state <= S_RS_INIT;
                    end else if ((r_best <= C_PAREN_HI) || !r_ploc_ok ||
                                 (r_ploc_kind != K_LIT)) begin
                        r_err   <= E_INVAL;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_PL_RD;
                    end
                end
                // Left operand in hand: apply the operator
                S_PL_RD: r_state <= S_PL_CHK;
                S_PL_CHK: begin
                    if (div_zero) begin
                        r_dbz   <= 1'b1;
                        r_state <= S_RS_INIT;
                    end else if (!long_op) begin
                        r_state <= S_RS_INIT;
                    end else begin
                        r_acc   <= '0;
                        r_mx    <= {64'd0, mag_a};
                        r_step  <= '0;
                        r_neg   <= a_val[63] ^ b_val[63];
                        r_a_neg <= a_val[63];
                        r_pass2 <= (r_loc_kind == K_INTDIV);
                        case (r_loc_kind)
                            K_MUL: begin
                                r_my <= mag_b;
                                r_d  <= ueff;
                            end
                            K_FRACDIV: begin
                                r_my <= ueff;
                                r_d  <= mag_b;
                            end
                            default: begin
                                r_my <= 64'd1;
                                r_d  <= mag_b;
                            end
                        endcase
                        r_state <= S_MUL;
                    end
                end
                // Shift-add product of x and y
                S_MUL: begin
                    if (r_my[0])
                        r_acc <= r_acc + r_mx;
                    r_mx   <= {r_mx[126:0], 1'b0};
                    r_my   <= {1'b0, r_my[63:1]};
                    if (r_step == MUL_LAST) begin
                        r_step  <= '0;
                        r_rem   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                // One quotient bit a cycle
                S_DIV: begin
                    r_rem  <= div_ge ? div_sub[63:0] : div_r2[63:0];
                    r_acc  <= {r_acc[126:0], div_ge};
                    r_step <= r_step + 1'b1;
                    if (r_step == DIV_LAST)
                        r_state <= S_OP_DONE;
                end
                S_OP_DONE: begin
                    if (r_pass2) begin
                        // Whole quotient times one unit
                        r_pass2 <= 1'b0;
                        r_mx    <= {64'd0, r_acc[63:0]};
                        r_my    <= ueff;
                        r_d     <= 64'd1;
                        r_acc   <= '0;
                        r_step  <= '0;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_RS_INIT;
                    end
                end
                // Hand over the result once the output word is free
                S_FIN: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= (r_err == E_OK) ? r_res : '0;
                        r_m_user  <= {r_dbz, r_err};
                        r_cnt     <= '0;
                        r_ovf     <= 1'b0;
                        r_badkind <= 1'b0;
                        r_state   <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

endmodule
